>>> design/assert_macros.svh
// Assertion macros for the checker file of the translation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> design/ptt_pkg.sv
// Types, codes and helper functions of the page table translation block.
package ptt_pkg;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned VaW     = 48;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AddrW-1:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitLarge   = 7;
  localparam logic [1:0] LastLevel = 2'd3;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_ENTRY     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ_REQ   = 2'd0,
    KIND_TRANSLATED = 2'd1,
    KIND_NOT_MAPPED = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TABLE_ROOT      = 2'd0,
    REG_DIRECT_MAP_BASE = 2'd1,
    REG_MMIO_BASE       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0] table_root;
    logic [AddrW-1:0] direct_map_base;
    logic [AddrW-1:0] mmio_base;
  } cfg_t;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] virt_addr;
    logic [AddrW-1:0] entry_data;
  } req_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] read_address;
    logic [AddrW-1:0] phys_addr;
    logic [AddrW-1:0] leaf_entry;
  } res_t;

  // Handshake between the input register and the walk stage.
  typedef struct packed {
    logic valid;
    req_t req;
  } in_stage_t;

  function automatic logic [IdxW-1:0] entry_index(logic [VaW-1:0] va, logic [1:0] level);
    logic [IdxW-1:0] idx;
    unique case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [VaW-1:0] offset_mask(logic [1:0] level);
    logic [VaW-1:0] m;
    unique case (level)
      2'd0:    m = {{(VaW-39){1'b0}}, {39{1'b1}}};
      2'd1:    m = {{(VaW-30){1'b0}}, {30{1'b1}}};
      2'd2:    m = {{(VaW-21){1'b0}}, {21{1'b1}}};
      default: m = {{(VaW-12){1'b0}}, {12{1'b1}}};
    endcase
    return m;
  endfunction

endpackage

>>> design/page_table_translate_core.sv
// Four-level page table walker: translates virtual addresses and issues entry reads.
//
// Each request is a translate command or a returned table entry; each yields exactly
// one result: a read request for the next table entry, a translated address, a
// not-mapped answer, or an unexpected-response flag. A request is first held in the
// input register, then passes through the translation logic and is loaded into the
// result register when the walk stage advances, and a new request is taken every
// cycle while the result side is not stalled. That rate is set by the walk state
// register (active flag, level, masked address), which is updated in the same cycle
// that the result register loads. Addresses inside the direct-map window
// [direct_map_base, mmio_base) are answered without any read and drop any walk in
// progress; a new translate command likewise aborts a walk. The configuration port
// is always ready; write it only while no request is in flight.
module page_table_translate_core import ptt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [AddrW-1:0]   virt_addr_i,
  input  logic [AddrW-1:0]   entry_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [AddrW-1:0]   read_address_o,
  output logic [AddrW-1:0]   phys_addr_o,
  output logic [AddrW-1:0]   leaf_entry_o
);

  cfg_t      cfg;
  in_stage_t stage;
  logic      advance;
  res_t      res;

  ptt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .virt_addr_i  (virt_addr_i),
    .entry_data_i (entry_data_i),
    .advance_i    (advance),
    .stage_o      (stage)
  );

  ptt_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o         = res.kind;
  assign read_address_o = res.read_address;
  assign phys_addr_o    = res.phys_addr;
  assign leaf_entry_o   = res.leaf_entry;

endmodule

>>> design/ptt_cfg_regs.sv
// Configuration register file of the translation block.
module ptt_cfg_regs import ptt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_TABLE_ROOT:      cfg_d.table_root      = cfg_data_i;
        REG_DIRECT_MAP_BASE: cfg_d.direct_map_base = cfg_data_i;
        REG_MMIO_BASE:       cfg_d.mmio_base       = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/ptt_in_stage.sv
// Input register that holds one accepted request for the walk stage.
module ptt_in_stage import ptt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [AddrW-1:0] virt_addr_i,
  input  logic [AddrW-1:0] entry_data_i,
  input  logic             advance_i,
  output in_stage_t        stage_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.command    <= cmd_e'(command_i);
      req_q.virt_addr  <= virt_addr_i;
      req_q.entry_data <= entry_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule

>>> design/ptt_walk.sv
// Walk state, per-request translation logic and result register.
module ptt_walk import ptt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  in_stage_t        stage_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             res_o
);

  logic           active_q, active_d;
  logic [1:0]     level_q, level_d;
  logic [VaW-1:0] vaddr_q, vaddr_d;
  logic           out_valid_q, out_valid_d;
  res_t           res_q, res_d;

  logic [AddrW-1:0] va;
  logic [AddrW-1:0] entry;
  logic             hit;
  logic [VaW-1:0]   va_masked;
  logic [1:0]       level_next;
  logic [VaW-1:0]   off_mask;
  logic [AddrW-1:0] leaf_frame;

  assign advance_o = stage_i.valid && (!out_valid_q || !out_stall_i);

  assign va         = stage_i.req.virt_addr;
  assign entry      = stage_i.req.entry_data;
  assign hit        = (va >= cfg_i.direct_map_base) && (va < cfg_i.mmio_base);
  assign va_masked  = va[VaW-1:0];
  assign level_next = level_q + 2'd1;
  assign off_mask   = offset_mask(level_q);
  assign leaf_frame = entry & FrameMask & ~{{(AddrW-VaW){1'b0}}, off_mask};

  always_comb begin
    active_d = active_q;
    level_d  = level_q;
    vaddr_d  = vaddr_q;
    res_d    = '0;
    res_d.kind = KIND_UNEXPECTED;
    case (stage_i.req.command)
      CMD_TRANSLATE: begin
        if (hit) begin
          active_d        = 1'b0;
          level_d         = 2'd0;
          res_d.kind      = KIND_TRANSLATED;
          res_d.phys_addr = va - cfg_i.direct_map_base;
        end else begin
          active_d           = 1'b1;
          level_d            = 2'd0;
          vaddr_d            = va_masked;
          res_d.kind         = KIND_READ_REQ;
          res_d.read_address = {cfg_i.table_root[AddrW-1:12],
                                entry_index(va_masked, 2'd0), 3'b000};
        end
      end
      default: begin
        if (!active_q) begin
          res_d.kind = KIND_UNEXPECTED;
        end else if (!entry[BitPresent]) begin
          active_d   = 1'b0;
          level_d    = 2'd0;
          res_d.kind = KIND_NOT_MAPPED;
        end else if (entry[BitLarge] || (level_q == LastLevel)) begin
          active_d         = 1'b0;
          level_d          = 2'd0;
          res_d.kind       = KIND_TRANSLATED;
          res_d.phys_addr  = leaf_frame | {{(AddrW-VaW){1'b0}}, vaddr_q & off_mask};
          res_d.leaf_entry = entry;
        end else begin
          level_d            = level_next;
          res_d.kind         = KIND_READ_REQ;
          res_d.read_address = {12'd0, entry[51:12],
                                entry_index(vaddr_q, level_next), 3'b000};
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      level_q     <= 2'd0;
      vaddr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        active_q <= active_d;
        level_q  <= level_d;
        vaddr_q  <= vaddr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/ptt_checker.sv
// Port-level checker of the translation block and its bind to the top level.
`include "assert_macros.svh"

module ptt_checker import ptt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic [AddrW-1:0]   read_address_o,
  input logic [AddrW-1:0]   phys_addr_o,
  input logic [AddrW-1:0]   leaf_entry_o
);

  `ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  `ASSERT_CLK(a_stalled_result_holds, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(read_address_o) && $stable(phys_addr_o) && $stable(leaf_entry_o))

  `ASSERT_CLK(a_read_req_fields, clk_i, rst_ni,
    out_valid_o && kind_o == KIND_READ_REQ |-> phys_addr_o == '0 &&
    leaf_entry_o == '0 && read_address_o[2:0] == 3'b000)

  `ASSERT_CLK(a_unexpected_zero, clk_i, rst_ni,
    out_valid_o && kind_o == KIND_UNEXPECTED |-> read_address_o == '0 &&
    phys_addr_o == '0 && leaf_entry_o == '0)

  `ASSERT_CLK(a_translated_no_read, clk_i, rst_ni,
    out_valid_o && (kind_o == KIND_TRANSLATED || kind_o == KIND_NOT_MAPPED) |->
    read_address_o == '0)

endmodule

bind page_table_translate_core ptt_checker u_ptt_checker (.*);

>>> bench/tb_top.sv
// Testbench for page_table_translate_core: random and directed page walks against a predictor.
module tb_top;
  import ptt_pkg::*;

  localparam int unsigned RandomItems = 1700;
  localparam int unsigned WalksPerPhase = 24;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [AddrW-1:0] AllOnes = {AddrW{1'b1}};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AddrW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [AddrW-1:0]   virt_addr_i;
  logic [AddrW-1:0]   entry_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         kind_o;
  logic [AddrW-1:0]   read_address_o;
  logic [AddrW-1:0]   phys_addr_o;
  logic [AddrW-1:0]   leaf_entry_o;

  logic [AddrW-1:0] root_reg;
  logic [AddrW-1:0] dmap_base_reg;
  logic [AddrW-1:0] mmio_base_reg;
  logic             walk_busy;
  logic [1:0]       walk_lvl;
  logic [VaW-1:0]   walk_va;

  res_t        pending_results[$];
  int unsigned items_sent;
  int unsigned errors;
  bit          no_idle;

  page_table_translate_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .virt_addr_i    (virt_addr_i),
    .entry_data_i   (entry_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .read_address_o (read_address_o),
    .phys_addr_o    (phys_addr_o),
    .leaf_entry_o   (leaf_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned page_shift(logic [1:0] lvl);
    return 39 - 9 * lvl;
  endfunction

  function automatic logic [AddrW-1:0] entry_address(logic [AddrW-1:0] tbl, logic [1:0] lvl,
                                                      logic [VaW-1:0] va);
    logic [AddrW-1:0] idx;
    idx = ({{(AddrW-VaW){1'b0}}, va} >> page_shift(lvl)) & 64'd511;
    return tbl + (idx << 3);
  endfunction

  task automatic predict_translation(cmd_e cmd, logic [AddrW-1:0] va, logic [AddrW-1:0] ent,
                                     output res_t r);
    logic [AddrW-1:0] off_mask;
    r = '0;
    r.kind = KIND_UNEXPECTED;
    if (cmd == CMD_TRANSLATE) begin
      if (va >= dmap_base_reg && va < mmio_base_reg) begin
        walk_busy = 1'b0;
        walk_lvl = 2'd0;
        r.kind = KIND_TRANSLATED;
        r.phys_addr = va - dmap_base_reg;
      end else begin
        walk_va = va[VaW-1:0];
        walk_lvl = 2'd0;
        walk_busy = 1'b1;
        r.kind = KIND_READ_REQ;
        r.read_address = entry_address(root_reg & ~64'hFFF, 2'd0, walk_va);
      end
    end else if (walk_busy) begin
      if (!ent[BitPresent]) begin
        walk_busy = 1'b0;
        walk_lvl = 2'd0;
        r.kind = KIND_NOT_MAPPED;
      end else if (ent[BitLarge] || walk_lvl == LastLevel) begin
        off_mask = (64'd1 << page_shift(walk_lvl)) - 64'd1;
        r.kind = KIND_TRANSLATED;
        r.phys_addr = (ent & FrameMask & ~off_mask) + ({{(AddrW-VaW){1'b0}}, walk_va} & off_mask);
        r.leaf_entry = ent;
        walk_busy = 1'b0;
        walk_lvl = 2'd0;
      end else begin
        walk_lvl = walk_lvl + 2'd1;
        r.kind = KIND_READ_REQ;
        r.read_address = entry_address(ent & FrameMask, walk_lvl, walk_va);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", {62'd0, kind_o}, '0);
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) report_mismatch("kind", {62'd0, kind_o}, {62'd0, want.kind});
        if (read_address_o !== want.read_address)
          report_mismatch("read_address", read_address_o, want.read_address);
        if (phys_addr_o !== want.phys_addr)
          report_mismatch("phys_addr", phys_addr_o, want.phys_addr);
        if (leaf_entry_o !== want.leaf_entry)
          report_mismatch("leaf_entry", leaf_entry_o, want.leaf_entry);
      end
    end
  end

  initial begin : drive_out_stall
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = idle_gap();
      if (hold != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  task automatic send_request(cmd_e cmd, logic [AddrW-1:0] va, logic [AddrW-1:0] ent);
    int unsigned gap;
    res_t want;
    gap = idle_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    virt_addr_i  <= va;
    entry_data_i <= ent;
    do @(posedge clk_i); while (in_stall_o);
    predict_translation(cmd, va, ent, want);
    pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic translate(logic [AddrW-1:0] va);
    send_request(CMD_TRANSLATE, va, rand64());
  endtask

  task automatic respond(logic [AddrW-1:0] ent);
    send_request(CMD_ENTRY, rand64(), ent);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TABLE_ROOT:      root_reg = data;
      REG_DIRECT_MAP_BASE: dmap_base_reg = data;
      REG_MMIO_BASE:       mmio_base_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [AddrW-1:0] root, logic [AddrW-1:0] base,
                            logic [AddrW-1:0] top);
    write_reg(REG_TABLE_ROOT, root);
    write_reg(REG_DIRECT_MAP_BASE, base);
    write_reg(REG_MMIO_BASE, top);
  endtask

  function automatic logic [AddrW-1:0] make_entry();
    logic [AddrW-1:0] e;
    e = rand64();
    e[BitPresent] = ($urandom_range(99) < 90);
    e[BitLarge] = ($urandom_range(99) < 20);
    return e;
  endfunction

  function automatic logic [AddrW-1:0] pick_vaddr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30 && mmio_base_reg > dmap_base_reg)
      return dmap_base_reg + rand64() % (mmio_base_reg - dmap_base_reg);
    case (r % 10)
      0: return '0;
      1: return AllOnes;
      2: return mmio_base_reg;
      3: return dmap_base_reg - 64'd1;
      default: return rand64();
    endcase
  endfunction

  task automatic walk_sequence();
    translate(pick_vaddr());
    while (walk_busy) begin
      if ($urandom_range(99) < 4) break;
      respond(make_entry());
    end
    if ($urandom_range(99) < 8) respond(rand64());
  endtask

  task automatic randomize_config();
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] span;
    int unsigned sel;
    sel = $urandom_range(9);
    base = (sel == 1) ? '0 : rand64();
    span = rand64() >> $urandom_range(0, 63);
    if ($urandom_range(9) == 0) write_reg(RegUnused, rand64());
    set_config(rand64(), base, (sel == 0) ? base - span : base + span);
  endtask

  task automatic test_reset_state();
    respond(AllOnes);
    translate('0);
    respond(64'h0000_0000_0000_1001);
    translate(AllOnes);
    respond('0);
    respond(64'h0000_0000_0000_0001);
    drain();
  endtask

  task automatic test_directed_walks();
    set_config(64'h0000_0000_1234_5FFF, 64'hFFFF_8880_0000_0000, 64'hFFFF_C900_0000_0000);
    write_reg(RegUnused, AllOnes);
    translate(64'hFFFF_8880_0000_0000);
    translate(64'hFFFF_C8FF_FFFF_FFFF);
    translate(64'hFFFF_C900_0000_0000);
    translate(64'hFFFF_887F_FFFF_FFFF);
    translate(64'hFFFF_0123_4567_89AB);
    respond(64'h8000_0000_0ABC_D063);
    respond(64'h0000_0000_0123_4027);
    respond(64'h7FF0_0000_0456_7003);
    respond(64'hFFF0_0000_0DEF_0067);
    translate(64'h0000_7FFF_FFFF_FFFF);
    respond(64'h0000_0000_0ABC_D003);
    respond(64'h0000_00FF_C000_0081);
    translate(64'h0000_1234_5678_9ABC);
    respond(64'h0000_0000_0ABC_D003);
    respond(64'h0000_0000_0111_1003);
    respond(64'h0000_0000_7654_30E3);
    translate(64'h0000_4000_0000_0000);
    respond(AllOnes);
    translate(64'h0000_4000_0000_0000);
    respond(64'h000F_FFFF_FFFF_F000);
    translate(64'h0000_0000_0000_1000);
    translate(64'hFFFF_9000_0000_0000);
    respond(64'h0000_0000_0000_0001);
    drain();
  endtask

  task automatic test_config_extremes();
    set_config(AllOnes, '0, AllOnes);
    translate('0);
    translate(64'h8000_0000_0000_0000);
    translate(AllOnes);
    respond(64'h0000_0000_0000_0001);
    drain();
    set_config('0, AllOnes, '0);
    translate(AllOnes);
    respond(64'h0000_0000_0000_0003);
    translate('0);
    drain();
    set_config(64'h000F_FFFF_FFFF_F000, 64'h0000_0000_0000_1000, 64'h0000_0000_0000_1000);
    translate(64'h0000_0000_0000_1000);
    respond(64'h0000_0000_0000_0081);
    drain();
  endtask

  task automatic test_random_traffic();
    while (items_sent < RandomItems) begin
      randomize_config();
      repeat (WalksPerPhase) walk_sequence();
      drain();
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    randomize_config();
    repeat (WalksPerPhase) walk_sequence();
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_TABLE_ROOT;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TRANSLATE;
    virt_addr_i   = '0;
    entry_data_i  = '0;
    root_reg      = '0;
    dmap_base_reg = '0;
    mmio_base_reg = '0;
    walk_busy     = 1'b0;
    walk_lvl      = 2'd0;
    walk_va       = '0;
    items_sent    = 0;
    errors        = 0;
    no_idle       = 1'b0;
    #1;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed_walks();
    test_config_extremes();
    test_back_to_back();
    test_random_traffic();
    test_back_to_back();

    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("page_table_translate_core verification clean");
    end else begin
      $display("page_table_translate_core verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("page_table_translate_core verification failed");
    $finish;
  end

endmodule
